[design/dmd_pkg.sv]
// Shared types and constants for the dependency mask dispatcher.
package dmd_pkg;

    localparam int SLOTS_DEFAULT = 32;

    localparam int DEP_W    = 32;
    localparam int STATUS_W = 2;
    localparam int IDX_W    = 5;
    localparam int CNT_W    = 6;

    localparam logic MODE_REGISTER = 1'b0;
    localparam logic MODE_DISPATCH = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL       = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NONE_READY = 2'd2;

    typedef struct packed {
        logic load_in;
        logic exec;
        logic load_out;
    } dmd_cmd_t;

endpackage

[design/dependency_mask_dispatcher.sv]
// Top level of the dependency mask dispatcher: sequencer plus datapath.
//
//   channel | handshake              | payload
//   --------+------------------------+--------------------------------------------
//   in      | in_valid / in_ready    | mode, dep_bits
//   out     | out_valid / out_ready  | status, task_index, dispatch_seq,
//           |                        | task_count, all_done, deadlock
//
// Each item passes the exec state, which searches the ready vector and commits
// the step, then the flags state, which evaluates the flags on the updated
// scoreboard. The next input beat is accepted in the flags state if the output
// register is free. Reset clears done bits, task count and sequence counter. A
// stalled output holds the item in the flags state until the output register drains.
module dependency_mask_dispatcher
#(
    parameter int SLOTS = dmd_pkg::SLOTS_DEFAULT
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          mode,
    input  logic [dmd_pkg::DEP_W-1:0]     dep_bits,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [dmd_pkg::STATUS_W-1:0]  status,
    output logic [dmd_pkg::IDX_W-1:0]     task_index,
    output logic [dmd_pkg::IDX_W-1:0]     dispatch_seq,
    output logic [dmd_pkg::CNT_W-1:0]     task_count,
    output logic                          all_done,
    output logic                          deadlock
);
    import dmd_pkg::*;

    dmd_cmd_t cmd;

    dmd_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    dmd_dpath #(
        .SLOTS (SLOTS)
    ) u_dpath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .mode         (mode),
        .dep_bits     (dep_bits),
        .status       (status),
        .task_index   (task_index),
        .dispatch_seq (dispatch_seq),
        .task_count   (task_count),
        .all_done     (all_done),
        .deadlock     (deadlock)
    );

endmodule

[design/dmd_ctrl.sv]
// Sequencer for the dispatcher: handshakes and datapath commands.
module dmd_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output dmd_pkg::dmd_cmd_t cmd
);
    import dmd_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FLAGS
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;
    logic   accept;

    // The output slot can take a new beat if empty or drained this cycle.
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == ST_IDLE) || ((state_reg == ST_FLAGS) && out_free);
    assign accept   = in_valid && in_ready;

    assign cmd.load_in  = accept;
    assign cmd.exec     = (state_reg == ST_EXEC);
    assign cmd.load_out = (state_reg == ST_FLAGS) && out_free;

    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_FLAGS;
            end
            ST_FLAGS:
            begin
                if (out_free)
                begin
                    state_next = accept ? ST_EXEC : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[design/dmd_dpath.sv]
// Task table, done bits, ready search and result registers.
module dmd_dpath
#(
    parameter int SLOTS = dmd_pkg::SLOTS_DEFAULT
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  dmd_pkg::dmd_cmd_t             cmd,
    input  logic                          mode,
    input  logic [dmd_pkg::DEP_W-1:0]     dep_bits,
    output logic [dmd_pkg::STATUS_W-1:0]  status,
    output logic [dmd_pkg::IDX_W-1:0]     task_index,
    output logic [dmd_pkg::IDX_W-1:0]     dispatch_seq,
    output logic [dmd_pkg::CNT_W-1:0]     task_count,
    output logic                          all_done,
    output logic                          deadlock
);
    import dmd_pkg::*;

    localparam int TW = $clog2(SLOTS + 1);
    localparam int SW = $clog2(SLOTS);

    // Input beat
    logic             mode_reg;
    logic [DEP_W-1:0] dep_in_reg;

    // Scoreboard
    logic [DEP_W-1:0] dep_reg [SLOTS];
    logic [SLOTS-1:0] done_reg;
    logic [TW-1:0]    total_reg;
    logic [CNT_W-1:0] seq_reg;

    // Step result, held until the flags are known
    logic [STATUS_W-1:0] res_status_reg;
    logic [IDX_W-1:0]    res_index_reg;
    logic [IDX_W-1:0]    res_seq_reg;

    // Output beat
    logic [STATUS_W-1:0] status_reg;
    logic [IDX_W-1:0]    task_index_reg;
    logic [IDX_W-1:0]    dispatch_seq_reg;
    logic [CNT_W-1:0]    task_count_reg;
    logic                all_done_reg;
    logic                deadlock_reg;

    logic [DEP_W-1:0] done_low;
    logic [SLOTS-1:0] live;
    logic [SLOTS-1:0] ready;
    logic [SW-1:0]    pick_idx;
    logic             any_ready;
    logic             every_done;
    logic             table_full;
    logic             do_register;
    logic             do_dispatch;

    genvar gi;

    // Only the low word of done bits can be named in a mask.
    generate
        for (gi = 0; gi < DEP_W; gi++)
        begin : g_done_low
            if (gi < SLOTS)
            begin : g_map
                assign done_low[gi] = done_reg[gi];
            end
            else
            begin : g_zero
                assign done_low[gi] = 1'b0;
            end
        end
    endgenerate

    // A dependency on an unfinished, unregistered or own index never clears.
    generate
        for (gi = 0; gi < SLOTS; gi++)
        begin : g_lane
            assign live[gi]  = (TW'(gi) < total_reg);
            assign ready[gi] = live[gi] && !done_reg[gi]
                               && ((dep_reg[gi] & ~done_low) == '0);
        end
    endgenerate

    always_comb
    begin
        pick_idx = '0;
        for (int k = SLOTS - 1; k >= 0; k--)
        begin
            if (ready[k])
            begin
                pick_idx = SW'(k);
            end
        end
    end

    assign any_ready   = |ready;
    assign every_done  = &(done_reg | ~live);
    assign table_full  = (total_reg == TW'(SLOTS));
    assign do_register = cmd.exec && (mode_reg == MODE_REGISTER) && !table_full;
    assign do_dispatch = cmd.exec && (mode_reg == MODE_DISPATCH) && any_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            mode_reg   <= mode;
            dep_in_reg <= dep_bits;
        end
    end

    generate
        for (gi = 0; gi < SLOTS; gi++)
        begin : g_table
            always_ff @(posedge clk)
            begin
                if (do_register && (total_reg == TW'(gi)))
                begin
                    dep_reg[gi] <= dep_in_reg;
                end
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= '0;
        end
        else if (do_dispatch)
        begin
            done_reg[pick_idx] <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= '0;
            seq_reg   <= '0;
        end
        else
        begin
            if (do_register)
            begin
                total_reg <= total_reg + TW'(1);
            end
            if (do_dispatch)
            begin
                seq_reg <= seq_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            res_status_reg <= STATUS_OK;
            res_index_reg  <= '0;
            res_seq_reg    <= '0;
            if (mode_reg == MODE_REGISTER)
            begin
                if (table_full)
                begin
                    res_status_reg <= STATUS_FULL;
                end
                else
                begin
                    res_index_reg <= IDX_W'(total_reg);
                end
            end
            else
            begin
                if (any_ready)
                begin
                    res_index_reg <= IDX_W'(pick_idx);
                    res_seq_reg   <= seq_reg[IDX_W-1:0];
                end
                else
                begin
                    res_status_reg <= STATUS_NONE_READY;
                end
            end
        end
    end

    // Flags read the scoreboard after the step has been committed.
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            status_reg       <= res_status_reg;
            task_index_reg   <= res_index_reg;
            dispatch_seq_reg <= res_seq_reg;
            task_count_reg   <= CNT_W'(total_reg);
            all_done_reg     <= every_done;
            deadlock_reg     <= !every_done && !any_ready;
        end
    end

    assign status       = status_reg;
    assign task_index   = task_index_reg;
    assign dispatch_seq = dispatch_seq_reg;
    assign task_count   = task_count_reg;
    assign all_done     = all_done_reg;
    assign deadlock     = deadlock_reg;

endmodule

[sim/tb_dependency_mask_dispatcher.sv]
// Self-checking testbench for the dependency mask dispatcher.
`timescale 1ns / 1ps

module tb_dependency_mask_dispatcher;

    import dmd_pkg::*;

    localparam int SLOTS        = SLOTS_DEFAULT;
    localparam int RANDOM_ITEMS = 934;
    localparam int STALL_LIMIT  = 400;
    localparam int DRAIN_CYCLES = 8;
    localparam int PRINT_LIMIT  = 60;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [IDX_W-1:0]    task_index;
        logic [IDX_W-1:0]    dispatch_seq;
        logic [CNT_W-1:0]    task_count;
        logic                all_done;
        logic                deadlock;
    } dispatch_result_t;

    class dispatch_scoreboard;
        logic [DEP_W-1:0] dep_table [SLOTS];
        logic [SLOTS-1:0] done_set;
        int unsigned      task_total;
        int unsigned      seq_next;
        dispatch_result_t awaited_q [$];
        int               errors;

        function new();
            done_set   = '0;
            task_total = 0;
            seq_next   = 0;
            errors     = 0;
        endfunction

        // Lowest pending task whose dependencies are all done, or -1.
        function int lowest_ready();
            for (int i = 0; i < task_total; i++)
            begin
                if (!done_set[i] && ((dep_table[i] & done_set[DEP_W-1:0]) == dep_table[i]))
                    return i;
            end
            return -1;
        endfunction

        function bit every_done();
            for (int i = 0; i < task_total; i++)
            begin
                if (!done_set[i])
                    return 0;
            end
            return 1;
        endfunction

        function void note_input(logic op, logic [DEP_W-1:0] mask);
            dispatch_result_t res;
            int               pick;
            res.status       = STATUS_OK;
            res.task_index   = '0;
            res.dispatch_seq = '0;
            if (op == MODE_REGISTER)
            begin
                if (task_total >= SLOTS)
                    res.status = STATUS_FULL;
                else
                begin
                    res.task_index       = task_total[IDX_W-1:0];
                    dep_table[task_total] = mask;
                    task_total++;
                end
            end
            else
            begin
                pick = lowest_ready();
                if (pick < 0)
                    res.status = STATUS_NONE_READY;
                else
                begin
                    res.task_index   = pick[IDX_W-1:0];
                    res.dispatch_seq = seq_next[IDX_W-1:0];
                    done_set[pick]   = 1'b1;
                    seq_next         = (seq_next + 1) % 64;
                end
            end
            res.task_count = task_total[CNT_W-1:0];
            res.all_done   = every_done();
            res.deadlock   = !res.all_done && (lowest_ready() < 0);
            awaited_q.push_back(res);
        endfunction

        task report(string msg);
            if (errors < PRINT_LIMIT)
                $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        task check_result(dispatch_result_t got);
            dispatch_result_t exp;
            if (awaited_q.size() == 0)
            begin
                report("result beat with nothing awaited");
                return;
            end
            exp = awaited_q.pop_front();
            if (got.status !== exp.status)
                report($sformatf("status %0d, want %0d", got.status, exp.status));
            if (got.task_index !== exp.task_index)
                report($sformatf("task_index %0d, want %0d", got.task_index, exp.task_index));
            if (got.dispatch_seq !== exp.dispatch_seq)
                report($sformatf("dispatch_seq %0d, want %0d",
                                 got.dispatch_seq, exp.dispatch_seq));
            if (got.task_count !== exp.task_count)
                report($sformatf("task_count %0d, want %0d", got.task_count, exp.task_count));
            if (got.all_done !== exp.all_done)
                report($sformatf("all_done %0b, want %0b", got.all_done, exp.all_done));
            if (got.deadlock !== exp.deadlock)
                report($sformatf("deadlock %0b, want %0b", got.deadlock, exp.deadlock));
        endtask
    endclass

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic                mode;
    logic [DEP_W-1:0]    dep_bits;
    logic                out_valid;
    logic                out_ready;
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    task_index;
    logic [IDX_W-1:0]    dispatch_seq;
    logic [CNT_W-1:0]    task_count;
    logic                all_done;
    logic                deadlock;

    dispatch_scoreboard sb;
    logic [DEP_W-1:0]   blocked_set;
    int                 send_calm;
    int                 recv_calm;
    int                 quiet_cycles;

    dependency_mask_dispatcher #(
        .SLOTS(SLOTS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .mode        (mode),
        .dep_bits    (dep_bits),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .task_index  (task_index),
        .dispatch_seq(dispatch_seq),
        .task_count  (task_count),
        .all_done    (all_done),
        .deadlock    (deadlock)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Mostly random waits, with runs of back-to-back beats mixed in.
    function automatic int draw_wait(ref int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
            calm = $urandom_range(8, 24);
        return $urandom_range(0, 6);
    endfunction

    task automatic send_beat(input logic op, input logic [DEP_W-1:0] mask);
        int gap;
        gap = draw_wait(send_calm);
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        mode     <= op;
        dep_bits <= mask;
        do @(posedge clk); while (!in_ready);
        sb.note_input(op, mask);
    endtask

    // Track tasks that may never dispatch so that chained masks can steer clear.
    task automatic register_task(input logic [DEP_W-1:0] mask, input bit may_block);
        if (may_block && sb.task_total < DEP_W)
            blocked_set[sb.task_total] = 1'b1;
        send_beat(MODE_REGISTER, mask);
    endtask

    task automatic dispatch_next();
        send_beat(MODE_DISPATCH, $urandom());
    endtask

    task automatic run_directed();
        dispatch_next();
        register_task('0, 0);
        register_task(32'h0000_0001, 0);
        register_task('0, 0);
        repeat (4) dispatch_next();
        // task depending on itself, on a not yet registered slot, on everything
        register_task(32'd1 << sb.task_total, 1);
        register_task(32'h8000_0000, 1);
        register_task('1, 1);
        register_task('0, 0);
        register_task(32'd1 << (sb.task_total - 1), 0);
        repeat (3) dispatch_next();
    endtask

    task automatic run_random();
        logic [DEP_W-1:0] chain;
        int               roll;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            roll = $urandom_range(0, 99);
            if (sb.task_total < SLOTS && roll < 45)
            begin
                // depend only on earlier tasks that can still finish
                chain = $urandom() & ~blocked_set;
                if (sb.task_total < DEP_W)
                    chain &= (32'd1 << sb.task_total) - 1;
                if ($urandom_range(0, 1) == 0)
                    chain &= $urandom();
                register_task(chain, 0);
            end
            else if (roll < 50)
                register_task($urandom(), 1);
            else
                dispatch_next();
        end
    endtask

    initial
    begin
        dispatch_result_t got;
        int               stall;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = draw_wait(recv_calm);
            @(negedge clk);
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            got.status       = status;
            got.task_index   = task_index;
            got.dispatch_seq = dispatch_seq;
            got.task_count   = task_count;
            got.all_done     = all_done;
            got.deadlock     = deadlock;
            sb.check_result(got);
        end
    end

    // Abort when neither channel moves a beat for too long.
    initial
    begin
        quiet_cycles = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        sb          = new();
        blocked_set = '0;
        send_calm   = 0;
        recv_calm   = 0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        mode        = MODE_REGISTER;
        dep_bits    = '0;
        out_ready   = 1'b0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        run_directed();
        run_random();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.awaited_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
